/* rtl/core/sorted_key_table_search_unit_assert.svh */
// Assertion macros for the sorted key table search unit.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef SORTED_KEY_TABLE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SKTS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SKTS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/skts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_pkg
// Shared types and constants of the sorted key table search unit.
// ----------------------------------------------------------------------------
package skts_pkg;

  localparam int unsigned TABLE_DEPTH = 16384;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 17;
  localparam int unsigned PopW    = 24;
  localparam int unsigned StatusW = 3;
  localparam int unsigned IdxW    = 14;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_APPENDED = 3'd0,
    ST_FULL     = 3'd1,
    ST_CLEARED  = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISSING  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [PopW-1:0] population;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/skts_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_if
// Valid/ready channels of the sorted key table search unit.
// ----------------------------------------------------------------------------
interface skts_in_if;
  logic                        valid;
  logic                        ready;
  logic [skts_pkg::OpW-1:0]    op;
  logic [skts_pkg::KeyW-1:0]   key;
  logic [skts_pkg::PopW-1:0]   population;

  modport source (output valid, output op, output key, output population, input ready);
  modport sink   (input valid, input op, input key, input population, output ready);
endinterface

interface skts_out_if;
  logic                         valid;
  logic                         ready;
  logic [skts_pkg::StatusW-1:0] status;
  logic [skts_pkg::IdxW-1:0]    entry_index;
  logic [skts_pkg::PopW-1:0]    entry_population;

  modport source (output valid, output status, output entry_index, output entry_population,
                  input ready);
  modport sink   (input valid, input status, input entry_index, input entry_population,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/skts_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skts_mem #(
  parameter int unsigned Depth = skts_pkg::TABLE_DEPTH,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire skts_pkg::entry_t  wdata_i,
  input  wire logic              re_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output skts_pkg::entry_t       rdata_o
);

  skts_pkg::entry_t mem_q [Depth];
  skts_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/skts_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_ctrl
// Sequencer: appends, clears, and linear or binary probing of the store.
// ----------------------------------------------------------------------------
module skts_ctrl #(
  parameter int unsigned TableDepth = skts_pkg::TABLE_DEPTH,
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW  = $clog2(TableDepth + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  skts_in_if.sink               in_i,
  skts_out_if.source            out_o,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output skts_pkg::entry_t      mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  wire skts_pkg::entry_t mem_rdata_i
);

  skts_pkg::state_e  state_q, state_d;
  logic              mode_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [CntW-1:0]   lo_q, lo_d;
  logic [CntW-1:0]   hi_q, hi_d;     // exclusive upper bound
  logic [skts_pkg::KeyW-1:0] key_q, key_d;

  skts_pkg::status_e         res_status_q, res_status_d;
  logic [skts_pkg::IdxW-1:0] res_idx_q, res_idx_d;
  logic [skts_pkg::PopW-1:0] res_pop_q, res_pop_d;

  logic                         out_valid_q, out_valid_d;
  logic [skts_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [skts_pkg::IdxW-1:0]    out_idx_q, out_idx_d;
  logic [skts_pkg::PopW-1:0]    out_pop_q, out_pop_d;

  logic            in_fire;
  logic            slot_free;
  logic            probe_hit;
  logic            probe_less;
  logic            probe_more;
  logic [CntW-1:0] probe_next;
  logic [CntW-1:0] bin_lo, bin_hi;
  logic [CntW-1:0] first_mid;
  logic            table_full;
  logic            table_empty;

  assign in_i.ready  = (state_q == skts_pkg::S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign slot_free   = !out_valid_q || out_o.ready;
  assign table_full  = (count_q == CntW'(TableDepth));
  assign table_empty = (count_q == '0);
  assign first_mid   = (count_q - CntW'(1)) >> 1;

  // Probe decision on the word read last cycle.
  always_comb begin
    probe_hit  = (mem_rdata_i.key == key_q);
    probe_less = (mem_rdata_i.key < key_q);
    bin_lo     = lo_q;
    bin_hi     = hi_q;
    if (mode_q) begin
      if (probe_less) begin
        bin_lo = ptr_q + CntW'(1);
      end else begin
        bin_hi = ptr_q;
      end
      probe_more = (bin_lo < bin_hi);
      probe_next = bin_lo + ((bin_hi - CntW'(1) - bin_lo) >> 1);
    end else begin
      probe_next = ptr_q + CntW'(1);
      probe_more = (probe_next < count_q);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      skts_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.op)
            skts_pkg::OP_APPEND,
            skts_pkg::OP_CLEAR:  state_d = skts_pkg::S_DONE;
            skts_pkg::OP_SEARCH: state_d = table_empty ? skts_pkg::S_DONE : skts_pkg::S_PROBE;
            default:             state_d = skts_pkg::S_IDLE;
          endcase
        end
      end
      skts_pkg::S_PROBE: begin
        if (probe_hit || !probe_more) begin
          state_d = skts_pkg::S_DONE;
        end
      end
      skts_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = skts_pkg::S_IDLE;
        end
      end
      default: state_d = skts_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_pop_d    = res_pop_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_pop_d    = out_pop_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_wdata_o.key        = in_i.key;
    mem_wdata_o.population = in_i.population;
    mem_waddr_o  = count_q[AddrW-1:0];

    unique case (state_q)
      skts_pkg::S_IDLE: begin
        if (in_fire) begin
          res_idx_d = '0;
          res_pop_d = '0;
          unique case (in_i.op)
            skts_pkg::OP_APPEND: begin
              if (table_full) begin
                res_status_d = skts_pkg::ST_FULL;
              end else begin
                mem_we_o     = 1'b1;
                count_d      = count_q + CntW'(1);
                res_status_d = skts_pkg::ST_APPENDED;
                res_idx_d    = skts_pkg::IdxW'(count_q);
              end
            end
            skts_pkg::OP_CLEAR: begin
              count_d      = '0;
              res_status_d = skts_pkg::ST_CLEARED;
            end
            skts_pkg::OP_SEARCH: begin
              key_d        = in_i.key;
              res_status_d = skts_pkg::ST_MISSING;
              lo_d         = '0;
              hi_d         = count_q;
              ptr_d        = mode_q ? first_mid : '0;
              mem_re_o     = !table_empty;
            end
            default: ;
          endcase
        end
      end
      skts_pkg::S_PROBE: begin
        lo_d = bin_lo;
        hi_d = bin_hi;
        if (probe_hit) begin
          res_status_d = skts_pkg::ST_FOUND;
          res_idx_d    = skts_pkg::IdxW'(ptr_q);
          res_pop_d    = mem_rdata_i.population;
        end else if (probe_more) begin
          ptr_d    = probe_next;
          mem_re_o = 1'b1;
        end else begin
          res_status_d = skts_pkg::ST_MISSING;
        end
      end
      skts_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = res_idx_q;
          out_pop_d    = res_pop_q;
        end
      end
      default: ;
    endcase
  end

  // Writes land only in idle and reads only during a search: no overlap.
  assign mem_raddr_o = ptr_d[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skts_pkg::S_IDLE;
      mode_q      <= 1'b1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_pop_q    <= res_pop_d;
    out_status_q <= out_status_d;
    out_idx_q    <= out_idx_d;
    out_pop_q    <= out_pop_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.entry_index      = out_idx_q;
  assign out_o.entry_population = out_pop_q;

endmodule
`default_nettype wire

/* rtl/core/sorted_key_table_search_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_search_unit
// Table of (key, population) entries with append, clear and key search.
// ----------------------------------------------------------------------------
// One item is processed at a time; the next is taken once the previous one
// has produced its result into the output register, even if that result is
// still waiting for the sink. Append and clear go from accept through the
// done state to the output register. A search reads the entry store once
// per cycle: binary mode needs at most ceil(log2(count+1)) probes (15 for a
// full 16384-entry table), linear mode up to count probes. A search of an
// empty table skips the probes and answers from the done state. Item op code
// 3 is consumed with no result. The store needs no clearing pass: only
// entries below the fill count are ever read.
module sorted_key_table_search_unit #(
  parameter int unsigned TableDepth = skts_pkg::TABLE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  skts_in_if.sink    in_i,
  skts_out_if.source out_o
);

  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  skts_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  skts_pkg::entry_t mem_rdata;

  skts_ctrl #(
    .TableDepth (TableDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  skts_mem #(
    .Depth (TableDepth)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
`default_nettype wire

/* rtl/core/skts_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_checker
// Port-level assertions for the sorted key table search unit.
// ----------------------------------------------------------------------------
`include "sorted_key_table_search_unit_assert.svh"

module skts_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic [skts_pkg::OpW-1:0]     in_op_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [skts_pkg::StatusW-1:0] out_status_i,
  input wire logic [skts_pkg::IdxW-1:0]    out_index_i,
  input wire logic [skts_pkg::PopW-1:0]    out_pop_i
);

  logic                         in_item;
  logic                         out_stall;
  logic                         out_same;
  logic                         no_payload;
  logic [skts_pkg::StatusW-1:0] status_q;
  logic [skts_pkg::IdxW-1:0]    index_q;
  logic [skts_pkg::PopW-1:0]    pop_q;

  // Result fields as seen at the previous edge.
  always_ff @(posedge clk_i) begin
    status_q <= out_status_i;
    index_q  <= out_index_i;
    pop_q    <= out_pop_i;
  end

  assign in_item    = in_valid_i && in_ready_i && (in_op_i == skts_pkg::OP_APPEND ||
                      in_op_i == skts_pkg::OP_CLEAR || in_op_i == skts_pkg::OP_SEARCH);
  assign out_stall  = out_valid_i && !out_ready_i;
  assign out_same   = (out_status_i == status_q) && (out_index_i == index_q) &&
                      (out_pop_i == pop_q);
  assign no_payload = out_valid_i && out_status_i != skts_pkg::ST_APPENDED &&
                      out_status_i != skts_pkg::ST_FOUND;

  `SKTS_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && out_same, "stalled result beat changed")
  `SKTS_ASSERT_NXT(a_one_item, in_item, !in_ready_i, "second item taken while one in flight")
  `SKTS_ASSERT_IMP(a_zero_fields, no_payload, out_index_i == '0 && out_pop_i == '0, "stray fields")
  `SKTS_ASSERT_IMP(a_status_code, out_valid_i, out_status_i <= 3'(skts_pkg::ST_MISSING), "bad status")

endmodule

bind sorted_key_table_search_unit skts_checker u_skts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_index_i  (out_o.entry_index),
  .out_pop_i    (out_o.entry_population)
);
`default_nettype wire

/* tb/sorted_key_table_search_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_search_unit_test
// Self-checking bench for the sorted key table search unit. A scoreboard
// keeps its own copy of the entry table and the search mode. Every accepted
// item but one with the unused op code is turned into an expected result beat, and each result beat is
// checked field by field against the oldest one. Stimulus covers directed
// corner cases, a longer ascending ladder searched in both modes, and
// random load/search sequences under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sorted_key_table_search_unit_test;

  localparam int unsigned HalfPeriodNs  = 2;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned WatchdogLimit = 60000;
  localparam int unsigned RandomItems   = 1220;
  localparam int unsigned SegmentItems  = 200;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned MaxPrinted    = 100;
  localparam int unsigned LadderLen     = 256;

  localparam int unsigned TableDepth = skts_pkg::TABLE_DEPTH;
  localparam int unsigned OpW        = skts_pkg::OpW;
  localparam int unsigned KeyW       = skts_pkg::KeyW;
  localparam int unsigned PopW       = skts_pkg::PopW;
  localparam int unsigned StatusW    = skts_pkg::StatusW;
  localparam int unsigned IdxW       = skts_pkg::IdxW;

  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam bit MODE_LINEAR = 1'b0;
  localparam bit MODE_BINARY = 1'b1;

  localparam int unsigned KeyMax = (1 << KeyW) - 1;
  localparam int unsigned PopMax = (1 << PopW) - 1;

  localparam string TbName = "sorted_key_table_search_unit_test";

  typedef struct packed {
    skts_pkg::status_e status;
    logic [IdxW-1:0]   slot;
    logic [PopW-1:0]   population;
  } lookup_result_t;

  typedef enum {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_COMB
  } rx_style_e;

  function automatic logic [KeyW-1:0] rand_key();
    return KeyW'($urandom_range(0, KeyMax));
  endfunction

  function automatic logic [PopW-1:0] rand_pop();
    return PopW'($urandom_range(0, PopMax));
  endfunction

  class search_scoreboard;
    logic [KeyW-1:0] key_mem [TableDepth];
    logic [PopW-1:0] pop_mem [TableDepth];
    int unsigned     fill;
    bit              binary_mode;
    lookup_result_t  awaited[$];
    int unsigned     errors;
    int unsigned     tally [8];

    function new();
      fill        = 0;
      binary_mode = MODE_BINARY;
      errors      = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    // Binary probe narrows exactly as the block does, sorted or not.
    function bit find_key(input logic [KeyW-1:0] key, output int unsigned hit);
      int lo;
      int hi;
      int mid;
      int unsigned i;
      hit = 0;
      if (binary_mode) begin
        lo = 0;
        hi = int'(fill) - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (key_mem[mid] == key) begin
            hit = unsigned'(mid);
            return 1'b1;
          end
          if (key_mem[mid] < key) lo = mid + 1;
          else hi = mid - 1;
        end
      end else begin
        for (i = 0; i < fill; i++) begin
          if (key_mem[i] == key) begin
            hit = i;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_input(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                             input logic [PopW-1:0] pop);
      lookup_result_t r;
      int unsigned    hit;
      r = '{status: skts_pkg::ST_APPENDED, slot: '0, population: '0};
      case (op)
        skts_pkg::OP_APPEND: begin
          if (fill < TableDepth) begin
            r.slot        = IdxW'(fill);
            key_mem[fill] = key;
            pop_mem[fill] = pop;
            fill++;
          end else begin
            r.status = skts_pkg::ST_FULL;
          end
        end
        skts_pkg::OP_CLEAR: begin
          fill     = 0;
          r.status = skts_pkg::ST_CLEARED;
        end
        skts_pkg::OP_SEARCH: begin
          if (find_key(key, hit)) begin
            r.status     = skts_pkg::ST_FOUND;
            r.slot       = IdxW'(hit);
            r.population = pop_mem[hit];
          end else begin
            r.status = skts_pkg::ST_MISSING;
          end
        end
        default: return;  // unused op code: consumed silently
      endcase
      awaited.push_back(r);
    endfunction

    task report_mismatch(input string what);
      if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(input logic [StatusW-1:0] status, input logic [IdxW-1:0] slot,
                      input logic [PopW-1:0] pop);
      lookup_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: status %0d index %0d",
                                  status, slot));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (slot !== want.slot)
        report_mismatch($sformatf("entry_index %0d, expected %0d", slot, want.slot));
      if (pop !== want.population)
        report_mismatch($sformatf("entry_population %0d, expected %0d", pop,
                                  want.population));
      tally[want.status]++;
    endtask
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we      = 1'b0;
  logic cfg_wdata   = 1'b0;

  search_scoreboard sb;

  int unsigned     items_sent   = 0;
  int unsigned     burst_left   = 0;
  int unsigned     hold_asked   = 0;
  int unsigned     hold_served  = 0;
  int unsigned     hold_left    = 0;
  int unsigned     style_left   = 0;
  int unsigned     rx_cycle     = 0;
  int unsigned     quiet_cycles = 0;
  rx_style_e       rx_style     = RX_OPEN;
  logic [KeyW-1:0] ladder [LadderLen];

  skts_in_if  in_if ();
  skts_out_if out_if ();

  sorted_key_table_search_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(HalfPeriodNs) clk_i = ~clk_i;

  // Result beats are checked before the input beat of the same edge: a
  // result can never belong to an item accepted at that very edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.status, out_if.entry_index, out_if.entry_population);
      if (in_if.valid && in_if.ready)
        sb.note_input(in_if.op, in_if.key, in_if.population);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("[%0t] no beat accepted for %0d cycles", $time, WatchdogLimit);
        $display("sorted_key_table_search_unit_test: done, errors");
        $finish;
      end
    end
  end

  // Receiver: stall style changes at random intervals; a requested
  // hold-off keeps ready low long enough to back the block up.
  always @(posedge clk_i) begin
    if (hold_asked != hold_served) begin
      hold_served = hold_asked;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style   = rx_style_e'($urandom_range(0, 3));
        style_left = $urandom_range(32, 400);
      end
      style_left--;
      rx_cycle++;
      case (rx_style)
        RX_OPEN:  out_if.ready <= 1'b1;
        RX_LIGHT: out_if.ready <= ($urandom_range(0, 9) < 7);
        RX_HEAVY: out_if.ready <= ($urandom_range(0, 9) < 3);
        default:  out_if.ready <= (rx_cycle % 4 != 0);
      endcase
    end
  end

  // Offers one item and returns at the edge where it is accepted. The
  // sender runs in bursts; a gap may open before the first beat of a burst.
  task automatic push_item(input logic [OpW-1:0] op, input logic [KeyW-1:0] key,
                           input logic [PopW-1:0] pop);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 60);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.key        <= key;
    in_if.population <= pop;
    do @(posedge clk_i); while (!in_if.ready);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic append_entry(input logic [KeyW-1:0] key, input logic [PopW-1:0] pop);
    push_item(skts_pkg::OP_APPEND, key, pop);
  endtask

  task automatic search_key(input logic [KeyW-1:0] key);
    push_item(skts_pkg::OP_SEARCH, key, rand_pop());
  endtask

  task automatic clear_table();
    push_item(skts_pkg::OP_CLEAR, rand_key(), rand_pop());
  endtask

  // Stop offering, wait for every expected beat, then let a trailing
  // silent item finish inside the block.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.binary_mode = mode;
  endtask

  // One load/search sequence: mostly a clear, ascending appends with random
  // spacing and populations, then searches for loaded, neighboring and
  // random keys. Some sequences are unsorted or skip the clear.
  task automatic run_sequence();
    int unsigned     n;
    int unsigned     m;
    int unsigned     i;
    int unsigned     kk;
    int unsigned     span;
    int unsigned     pick;
    bit              ascending;
    logic [KeyW-1:0] k;
    logic [KeyW-1:0] loaded[$];
    n         = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 300) : $urandom_range(0, 40);
    ascending = ($urandom_range(0, 7) != 0);
    if ($urandom_range(0, 9) != 0) clear_table();
    kk = $urandom_range(0, 3000);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        push_item(OP_UNUSED, rand_key(), rand_pop());
      else if (pick == 1)
        search_key(rand_key());
      if (ascending) begin
        span = (KeyMax - kk) / (n - i + 1);
        if ($urandom_range(0, 9) != 0 && span > 0) kk += $urandom_range(1, span);
        k = KeyW'(kk);
      end else begin
        k = rand_key();
      end
      append_entry(k, rand_pop());
      loaded.push_back(k);
    end
    m = $urandom_range(1, 12);
    for (i = 0; i < m; i++) begin
      pick = $urandom_range(0, 9);
      if (loaded.size() != 0 && pick < 6)
        k = loaded[$urandom_range(0, loaded.size() - 1)];
      else if (loaded.size() != 0 && pick < 8)
        k = loaded[$urandom_range(0, loaded.size() - 1)] +
            KeyW'(($urandom_range(0, 1) != 0) ? 1 : KeyMax);
      else
        k = rand_key();
      search_key(k);
    end
  endtask

  initial begin
    int unsigned i;
    int unsigned seg;
    int unsigned rand_start;
    sb = new();
    in_if.valid      = 1'b0;
    in_if.op         = skts_pkg::OP_APPEND;
    in_if.key        = '0;
    in_if.population = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, binary mode out of reset.
    search_key(17'd42);                          // empty table
    push_item(OP_UNUSED, '1, '1);
    append_entry(17'd0, 24'd0);
    append_entry(17'd5, 24'd123);
    append_entry(17'd99999, PopW'(PopMax));
    append_entry(KeyW'(KeyMax), 24'hABCDEF);     // above the postal range
    search_key(17'd0);
    search_key(17'd99999);
    search_key(KeyW'(KeyMax));
    search_key(17'd5);
    search_key(17'd6);
    clear_table();
    search_key(17'd5);                           // stale entry after clear
    append_entry(17'd50, 24'd1);
    append_entry(17'd90, 24'd2);
    append_entry(17'd10, 24'd3);
    search_key(17'd10);                          // unsorted: probe misses it
    settle();
    write_mode(MODE_LINEAR);
    search_key(17'd10);
    append_entry(17'd50, 24'd4);
    search_key(17'd50);                          // first of two equal keys
    search_key(17'd77);
    clear_table();
    search_key(17'd50);
    settle();

    // Ascending ladder, lookups at both ends and around random rungs.
    write_mode(MODE_BINARY);
    clear_table();
    for (i = 0; i < LadderLen; i++) begin
      ladder[i] = KeyW'(i * 6 + $urandom_range(0, 5));
      append_entry(ladder[i], rand_pop());
    end
    push_item(OP_UNUSED, '0, '0);
    search_key(ladder[0]);
    search_key(ladder[LadderLen-1]);
    search_key(KeyW'(KeyMax));
    for (i = 0; i < 40; i++) begin
      seg = $urandom_range(0, LadderLen - 1);
      search_key(ladder[seg] + KeyW'($urandom_range(0, 1)));
    end
    settle();
    write_mode(MODE_LINEAR);
    search_key(ladder[0]);
    search_key(ladder[LadderLen-1]);             // scans the whole ladder
    search_key(KeyW'(KeyMax));
    settle();

    // Random part in segments, mode toggled between them.
    rand_start = items_sent;
    seg = 0;
    while (items_sent - rand_start < RandomItems) begin
      if (items_sent - rand_start >= seg * SegmentItems) begin
        settle();
        write_mode(seg % 2 == 0 ? MODE_BINARY : MODE_LINEAR);
        if (seg == 1 || seg == 4) hold_asked++;
        seg++;
      end
      run_sequence();
    end
    settle();

    $display("%s: %0d items, %0d appended, %0d full, %0d cleared, %0d found, %0d missing",
             TbName, items_sent, sb.tally[skts_pkg::ST_APPENDED],
             sb.tally[skts_pkg::ST_FULL], sb.tally[skts_pkg::ST_CLEARED],
             sb.tally[skts_pkg::ST_FOUND], sb.tally[skts_pkg::ST_MISSING]);
    $display("%s: %0d-entry ladder in both modes, %0d receiver hold-offs, %0d mismatches",
             TbName, LadderLen, hold_served, sb.errors);
    if (sb.errors == 0) begin
      $display("sorted_key_table_search_unit_test: done, clean");
    end else begin
      $display("sorted_key_table_search_unit_test: done, errors");
    end
    $finish;
  end

endmodule
